// File: src/ssi_aft_pkg.sv
// ----------------------------------------------------------------------------
// SSI angle frame tracker - shared definitions
// Field widths, register map, opcodes and status decoding for the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_aft_pkg;

	// sensor and angle geometry
	localparam int RAW_BITS    = 14;
	localparam int ANGLE_BITS  = 32;
	localparam int FRAME_W     = 24;
	localparam int RAW_SHIFT   = FRAME_W - RAW_BITS;
	localparam int STAT_SHIFT  = 6;
	localparam int STAT_W      = 4;
	localparam int HALF_W      = 14;
	localparam int STEP_W      = 32;
	localparam int RAW_OUT_W   = 14;
	localparam int ANGLE_OUT_W = 32;

	// signed delta wide enough for the raw difference and for -half_range
	localparam int DIFF_W = ((RAW_BITS > HALF_W) ? RAW_BITS : HALF_W) + 2;
	localparam logic signed [DIFF_W-1:0] RAW_TURN = DIFF_W'(1) << RAW_BITS;

	// status decoding
	localparam logic [STAT_W-1:0] STAT_HARD = 4'h8;
	localparam logic [STAT_W-1:0] STAT_PAIR = 4'h3;

	// register map and resets
	localparam logic      REG_TURN_STEP  = 1'b0;
	localparam logic      REG_HALF_RANGE = 1'b1;
	localparam int        PADDR_W        = 3;
	localparam int        PDATA_W        = 32;
	localparam logic [STEP_W-1:0] STEP_RESET = 32'd262144;
	localparam logic [HALF_W-1:0] HALF_RESET = 14'd8192;

	// opcodes
	localparam logic OP_INIT = 1'b0;
	localparam logic OP_READ = 1'b1;

	// stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 1;
	localparam int M_FIELD_W = STAT_W + ANGLE_OUT_W + RAW_OUT_W;

	function automatic logic status_is_fault(input logic [STAT_W-1:0] s);
		status_is_fault = ((s & STAT_HARD) != '0) || ((s & STAT_PAIR) == STAT_PAIR);
	endfunction

endpackage

`default_nettype wire

// File: src/ssi_angle_frame_tracker_unit.sv
// ----------------------------------------------------------------------------
// SSI angle frame tracker
// Unwraps the raw sensor angle delta and integrates it into an electrical
// turn fraction, scaled by a programmable step.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: frame; tuser: opcode, rx_ok
//  m_*     | out | m_tvalid/m_tready  | tdata: status, elec angle, raw; tuser: fault
//  apb     | in  | psel/penable       | turn_step @0x0, half_range @0x4
//
//  One request per cycle sustained while m_tready stays high; each request
//  passes through the input register, then the result register.
//  The limit is the state loop: delta, one 32x32 low-half multiply and the
//  accumulate all settle between the input register and the result register.
//  Reset (arst_n low) clears state to zero and the registers to their defaults.
//  A stalled result holds and the state does not move; the input register
//  still takes one more request, then s_tready drops until the result drains.
//
`default_nettype none

module ssi_angle_frame_tracker_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssi_aft_pkg::PADDR_W-1:0]   paddr,
	input  logic [ssi_aft_pkg::PDATA_W-1:0]   pwdata,
	output logic [ssi_aft_pkg::PDATA_W-1:0]   prdata,
	output logic                              pready,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ssi_aft_pkg::S_TDATA_W-1:0] s_tdata,  // [23:0] frame
	input  logic [ssi_aft_pkg::S_TUSER_W-1:0] s_tuser,  // [0] opcode, [1] rx_ok
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ssi_aft_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] sensor_status,
	                                                    // [35:4] elec_angle,
	                                                    // [49:36] raw_angle, rest zero
	output logic [ssi_aft_pkg::M_TUSER_W-1:0] m_tuser   // [0] init_fault
);

	// ---------------------------------------------------------------- config
	logic [ssi_aft_pkg::STEP_W-1:0] turn_step_q;
	logic [ssi_aft_pkg::HALF_W-1:0] half_range_q;
	logic                           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// decode on the word address bit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_step_q  <= ssi_aft_pkg::STEP_RESET;
			half_range_q <= ssi_aft_pkg::HALF_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				ssi_aft_pkg::REG_TURN_STEP:  turn_step_q  <= pwdata[ssi_aft_pkg::STEP_W-1:0];
				ssi_aft_pkg::REG_HALF_RANGE: half_range_q <= pwdata[ssi_aft_pkg::HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ssi_aft_pkg::REG_TURN_STEP:  prdata = ssi_aft_pkg::PDATA_W'(turn_step_q);
			ssi_aft_pkg::REG_HALF_RANGE: prdata = ssi_aft_pkg::PDATA_W'(half_range_q);
			default:                     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- input stage
	logic                            valid_s1;
	logic                            op_s1;
	logic                            ok_s1;
	logic [ssi_aft_pkg::FRAME_W-1:0] frame_s1;
	logic                            out_valid_q;
	logic                            advance;
	logic                            s_acc;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1    <= s_tuser[0];
			ok_s1    <= s_tuser[1];
			frame_s1 <= s_tdata[ssi_aft_pkg::FRAME_W-1:0];
		end
	end

	// ---------------------------------------------------------- state update
	logic [ssi_aft_pkg::RAW_BITS-1:0]   last_raw_q;
	logic [ssi_aft_pkg::ANGLE_BITS-1:0] angle_acc_q;
	logic [ssi_aft_pkg::STAT_W-1:0]     status_q;

	logic [ssi_aft_pkg::RAW_BITS-1:0]   raw_new;
	logic [ssi_aft_pkg::STAT_W-1:0]     st_new;
	logic signed [ssi_aft_pkg::DIFF_W-1:0] raw_x, last_x, half_x, diff_raw, diff;
	logic [ssi_aft_pkg::ANGLE_BITS-1:0] diff_ext, prod;

	logic [ssi_aft_pkg::RAW_BITS-1:0]   last_raw_d;
	logic [ssi_aft_pkg::ANGLE_BITS-1:0] angle_acc_d;
	logic [ssi_aft_pkg::STAT_W-1:0]     status_d;
	logic                               fault_d;

	assign raw_new = frame_s1[ssi_aft_pkg::RAW_SHIFT +: ssi_aft_pkg::RAW_BITS];
	assign st_new  = frame_s1[ssi_aft_pkg::STAT_SHIFT +: ssi_aft_pkg::STAT_W];

	// delta folded into half a turn either way
	always_comb begin
		raw_x    = ssi_aft_pkg::DIFF_W'(raw_new);
		last_x   = ssi_aft_pkg::DIFF_W'(last_raw_q);
		half_x   = ssi_aft_pkg::DIFF_W'(half_range_q);
		diff_raw = raw_x - last_x;
		if (diff_raw < -half_x) begin
			diff = diff_raw + ssi_aft_pkg::RAW_TURN;
		end else if (diff_raw > half_x) begin
			diff = diff_raw - ssi_aft_pkg::RAW_TURN;
		end else begin
			diff = diff_raw;
		end
	end

	// signed delta times step, low half only: the angle wraps per turn
	assign diff_ext = ssi_aft_pkg::ANGLE_BITS'(diff);
	assign prod     = diff_ext * ssi_aft_pkg::ANGLE_BITS'(turn_step_q);

	always_comb begin
		last_raw_d  = last_raw_q;
		angle_acc_d = angle_acc_q;
		status_d    = status_q;
		fault_d     = 1'b0;
		case (op_s1)
			ssi_aft_pkg::OP_INIT: begin
				status_d = st_new;
				if (ssi_aft_pkg::status_is_fault(st_new)) begin
					fault_d = 1'b1;
				end else begin
					last_raw_d  = raw_new;
					angle_acc_d = '0;
				end
			end
			ssi_aft_pkg::OP_READ: begin
				// failed receive leaves everything as it was
				if (ok_s1) begin
					status_d    = st_new;
					angle_acc_d = angle_acc_q + prod;
					last_raw_d  = raw_new;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= '0;
			angle_acc_q <= '0;
			status_q    <= '0;
		end else if (advance) begin
			last_raw_q  <= last_raw_d;
			angle_acc_q <= angle_acc_d;
			status_q    <= status_d;
		end
	end

	// --------------------------------------------------------- result stage
	logic [ssi_aft_pkg::M_TDATA_W-1:0] out_data_q;
	logic                              out_fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q  <= ssi_aft_pkg::M_TDATA_W'({
				ssi_aft_pkg::RAW_OUT_W'(last_raw_d),
				ssi_aft_pkg::ANGLE_OUT_W'(angle_acc_d),
				status_d});
			out_fault_q <= fault_d;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_fault_q;

endmodule

`default_nettype wire

// File: src/ssi_aft_checker.sv
// ----------------------------------------------------------------------------
// SSI angle frame tracker - port checker
// Concurrent checks on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_aft_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [ssi_aft_pkg::PADDR_W-1:0]   paddr,
	input logic [ssi_aft_pkg::PDATA_W-1:0]   pwdata,
	input logic [ssi_aft_pkg::PDATA_W-1:0]   prdata,
	input logic                              pready,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [ssi_aft_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [ssi_aft_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ssi_aft_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [ssi_aft_pkg::M_TUSER_W-1:0] m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input only backs up when the result side is full and stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// a flagged init fault must carry a fault status
	a_fault_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[3] || (m_tdata[1:0] == 2'b11))
		else $error("init fault flagged on a good status");

	// padding above the fields stays clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ssi_aft_pkg::M_TDATA_W-1:ssi_aft_pkg::M_FIELD_W] == '0)
		else $error("result padding not zero");

endmodule

bind ssi_angle_frame_tracker_unit ssi_aft_checker u_ssi_aft_checker (.*);

`default_nettype wire
